// ===== rtl/core/rmv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running statistics package
// Widths, reset and limit constants, controller states and the command and status
// groups shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package rmv_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned CountW  = 32;
  localparam int unsigned M2W     = 64;
  localparam int unsigned VarW    = 63;

  localparam logic [SampleW-1:0] SampleMax = {1'b0, {(SampleW-1){1'b1}}};
  localparam logic [SampleW-1:0] SampleMin = {1'b1, {(SampleW-1){1'b0}}};
  localparam logic [CountW-1:0]  CountMax  = {CountW{1'b1}};
  localparam logic [VarW-1:0]    VarMax    = {VarW{1'b1}};

  typedef enum logic [2:0] {
    StIdle,
    StSetup,
    StDivMean,
    StMult,
    StAccum,
    StVarStart,
    StDivVar,
    StPublish
  } rmv_state_e;

  typedef struct packed {
    logic capture;
    logic setup;
    logic upd_mean;
    logic mult;
    logic accum;
    logic start_var;
    logic upd_var;
    logic load_out;
  } rmv_cmd_t;

  typedef struct packed {
    logic full;
    logic multi;
    logic div_done;
  } rmv_status_t;

endpackage

// ===== rtl/core/rmv_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running statistics stream interfaces
// Valid/ready channels for the sample request and the statistics result.
// ----------------------------------------------------------------------------
interface rmv_in_if
  import rmv_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface rmv_out_if
  import rmv_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [CountW-1:0]  sample_count;
  logic [SampleW-1:0] running_mean;
  logic [SampleW-1:0] minimum;
  logic [SampleW-1:0] maximum;
  logic [VarW-1:0]    sample_variance;
  logic               overflow;

  modport source (output valid, output sample_count, output running_mean,
                  output minimum, output maximum, output sample_variance,
                  output overflow, input ready);
  modport sink   (input valid, input sample_count, input running_mean,
                  input minimum, input maximum, input sample_variance,
                  input overflow, output ready);
endinterface

// ===== rtl/core/running_mean_variance_min_max.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running mean, variance, minimum and maximum
// The first request skips the variance division; one finding the count full
// skips both divisions and sets the overflow flag. Requests are taken one
// at a time, a new one only once the last result is loaded for hand-off.
// The shared divider (two quotient bits per cycle) runs short for the mean,
// long for the variance. A finished result waits in the output register.
// Reset: asynchronous, active low; statistics return to their reset values.
// ----------------------------------------------------------------------------
module running_mean_variance_min_max
  import rmv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  rmv_in_if.sink      in_i,
  rmv_out_if.source   out_o
);

  rmv_cmd_t    cmd;
  rmv_status_t status;

  rmv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rmv_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .sample_i          (in_i.sample),
    .sample_count_o    (out_o.sample_count),
    .running_mean_o    (out_o.running_mean),
    .minimum_o         (out_o.minimum),
    .maximum_o         (out_o.maximum),
    .sample_variance_o (out_o.sample_variance),
    .overflow_o        (out_o.overflow)
  );

endmodule

// ===== rtl/core/rmv_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running statistics divider
// Restoring unsigned divider, two quotient bits per cycle, 64-bit dividend
// and 32-bit divisor. A short run covers the upper half of the dividend.
// ----------------------------------------------------------------------------
module rmv_divider
  import rmv_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 long_i,
  input  logic [M2W-1:0]       dividend_i,
  input  logic [CountW-1:0]    divisor_i,
  output logic                 done_o,
  output logic [M2W-1:0]       quotient_o
);

  localparam int unsigned CntW = $clog2(M2W / 2);
  localparam logic [CntW-1:0] LongLast  = CntW'(M2W / 2 - 1);
  localparam logic [CntW-1:0] ShortLast = CntW'(M2W / 4 - 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [M2W-1:0]      dq_q, dq_d;
  logic [CountW-1:0]   rem_q, rem_d;
  logic [CountW-1:0]   div_q, div_d;
  logic [CountW:0]     s1, s2;

  function automatic logic [CountW:0] div_step(input logic [CountW-1:0] rem,
                                               input logic              nb,
                                               input logic [CountW-1:0] d);
    logic [CountW:0] t;
    logic [CountW:0] diff;
    t    = {rem, nb};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      return {1'b1, diff[CountW-1:0]};
    end else begin
      return {1'b0, t[CountW-1:0]};
    end
  endfunction

  always_comb begin
    s1     = div_step(rem_q, dq_q[M2W-1], div_q);
    s2     = div_step(s1[CountW-1:0], dq_q[M2W-2], div_q);
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = long_i ? LongLast : ShortLast;
      dq_d   = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      dq_d  = {dq_q[M2W-3:0], s1[CountW], s2[CountW]};
      rem_d = s2[CountW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

// ===== rtl/core/rmv_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running statistics datapath
// Holds count, mean, min, max, m2 and variance, the product register, the
// shared divider and the result register, all steered by controller commands.
// ----------------------------------------------------------------------------
module rmv_datapath
  import rmv_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rmv_cmd_t             cmd_i,
  output rmv_status_t          status_o,
  input  logic [SampleW-1:0]   sample_i,
  output logic [CountW-1:0]    sample_count_o,
  output logic [SampleW-1:0]   running_mean_o,
  output logic [SampleW-1:0]   minimum_o,
  output logic [SampleW-1:0]   maximum_o,
  output logic [VarW-1:0]      sample_variance_o,
  output logic                 overflow_o
);

  logic [SampleW-1:0] x_q;
  logic [CountW-1:0]  count_q;
  logic [SampleW-1:0] mean_q;
  logic [SampleW-1:0] min_q;
  logic [SampleW-1:0] max_q;
  logic [M2W-1:0]     m2_q;
  logic [VarW-1:0]    var_q;
  logic               ovf_q;
  logic [SampleW-1:0] mag_q;
  logic               neg_q;
  logic [M2W-1:0]     prod_q;

  logic [SampleW:0]   delta;
  logic [SampleW:0]   delta_abs;
  logic [SampleW-1:0] mag;
  logic [CountW-1:0]  n;
  logic [M2W:0]       sum;
  logic               div_start;
  logic [M2W-1:0]     div_dividend;
  logic [CountW-1:0]  div_divisor;
  logic               div_done;
  logic [M2W-1:0]     quotient;
  logic [SampleW-1:0] q_mean;

  assign delta     = {x_q[SampleW-1], x_q} - {mean_q[SampleW-1], mean_q};
  assign delta_abs = delta[SampleW] ? (~delta + 1'b1) : delta;
  assign mag       = delta_abs[SampleW-1:0];
  assign n         = count_q + 1'b1;
  assign sum       = {1'b0, m2_q} + {1'b0, prod_q};
  assign q_mean    = quotient[SampleW-1:0];

  assign div_start    = (cmd_i.setup && (count_q != CountMax)) || cmd_i.start_var;
  assign div_dividend = cmd_i.start_var ? m2_q : {mag, {(M2W-SampleW){1'b0}}};
  assign div_divisor  = cmd_i.start_var ? (count_q - 1'b1) : n;

  rmv_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .long_i     (cmd_i.start_var),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign status_o.full     = (count_q == CountMax);
  assign status_o.multi    = (count_q > CountW'(1));
  assign status_o.div_done = div_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      mean_q  <= '0;
      min_q   <= SampleMax;
      max_q   <= SampleMin;
      m2_q    <= '0;
      var_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        ovf_q <= 1'b0;
      end
      if (cmd_i.setup) begin
        if (count_q == CountMax) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= n;
          if ($signed(x_q) > $signed(max_q)) begin
            max_q <= x_q;
          end
          if ($signed(x_q) < $signed(min_q)) begin
            min_q <= x_q;
          end
        end
      end
      if (cmd_i.upd_mean) begin
        mean_q <= neg_q ? (mean_q - q_mean) : (mean_q + q_mean);
      end
      if (cmd_i.accum) begin
        if (sum[M2W]) begin
          m2_q  <= {M2W{1'b1}};
          ovf_q <= 1'b1;
        end else begin
          m2_q <= sum[M2W-1:0];
        end
      end
      if (cmd_i.upd_var) begin
        var_q <= quotient[M2W-1] ? VarMax : quotient[VarW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x_q <= sample_i;
    end
    if (cmd_i.setup) begin
      mag_q <= mag;
      neg_q <= delta[SampleW];
    end
    if (cmd_i.mult) begin
      prod_q <= M2W'(mag_q) * M2W'(mag);
    end
    if (cmd_i.load_out) begin
      sample_count_o    <= count_q;
      running_mean_o    <= mean_q;
      minimum_o         <= min_q;
      maximum_o         <= max_q;
      sample_variance_o <= var_q;
      overflow_o        <= ovf_q;
    end
  end

endmodule

// ===== rtl/core/rmv_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running statistics controller
// Sequences one request through setup, mean division, product, m2 update,
// variance division and result hand-off, and owns the result valid flag.
// ----------------------------------------------------------------------------
module rmv_ctrl
  import rmv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  rmv_status_t status_i,
  output rmv_cmd_t    cmd_o
);

  rmv_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StSetup;
        end
      end
      StSetup: begin
        cmd_o.setup = 1'b1;
        state_d     = status_i.full ? StPublish : StDivMean;
      end
      StDivMean: begin
        if (status_i.div_done) begin
          cmd_o.upd_mean = 1'b1;
          state_d        = StMult;
        end
      end
      StMult: begin
        cmd_o.mult = 1'b1;
        state_d    = StAccum;
      end
      StAccum: begin
        cmd_o.accum = 1'b1;
        state_d     = StVarStart;
      end
      StVarStart: begin
        if (status_i.multi) begin
          cmd_o.start_var = 1'b1;
          state_d         = StDivVar;
        end else begin
          state_d = StPublish;
        end
      end
      StDivVar: begin
        if (status_i.div_done) begin
          cmd_o.upd_var = 1'b1;
          state_d       = StPublish;
        end
      end
      StPublish: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/rmv_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running statistics checker
// Port-level properties of the running statistics block, bound to its top.
// ----------------------------------------------------------------------------
module rmv_checker
  import rmv_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [CountW-1:0]  count_i,
  input logic [SampleW-1:0] min_i,
  input logic [SampleW-1:0] max_i,
  input logic [VarW-1:0]    var_i,
  input logic               ovf_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(count_i) &&
      $stable(min_i) && $stable(max_i) && $stable(var_i) && $stable(ovf_i))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while another is in progress");

  a_var_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (count_i < CountW'(2)) |-> var_i == '0)
    else $error("variance nonzero below two samples");

  a_min_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (count_i != '0) |-> $signed(min_i) <= $signed(max_i))
    else $error("minimum above maximum");

endmodule

bind running_mean_variance_min_max rmv_checker u_rmv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .count_i     (out_o.sample_count),
  .min_i       (out_o.minimum),
  .max_i       (out_o.maximum),
  .var_i       (out_o.sample_variance),
  .ovf_i       (out_o.overflow)
);

// ===== test/tb_running_mean_variance_min_max.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the running mean, variance, minimum and maximum block
// Sends signed Q16.16 samples through the request channel and predicts every
// result with a fixed-point running-statistics model kept in a scoreboard.
// Each returned result is compared field by field with the oldest prediction.
// Random idle bursts fall on both channels. Squared-deviation saturation is
// left until the end of the run, because once it happens it holds until reset.
// ----------------------------------------------------------------------------
module tb_running_mean_variance_min_max;
  import rmv_pkg::*;

  localparam int unsigned QuietLimit = 2000;

  typedef struct {
    logic [CountW-1:0]  count;
    logic [SampleW-1:0] mean;
    logic [SampleW-1:0] low;
    logic [SampleW-1:0] high;
    logic [VarW-1:0]    variance;
    logic               ovf;
  } stats_t;

  class stats_tracker;
    logic [CountW-1:0] n_seen;
    longint            mean_acc;
    longint            min_acc;
    longint            max_acc;
    logic [M2W-1:0]    sq_dev;
    logic [VarW-1:0]   var_held;
    stats_t            expected_stats[$];
    int unsigned       errors;

    function new();
      n_seen   = '0;
      mean_acc = 0;
      min_acc  = longint'($signed(SampleMax));
      max_acc  = longint'($signed(SampleMin));
      sq_dev   = '0;
      var_held = '0;
      errors   = 0;
    endfunction

    function void record_sample(input logic [SampleW-1:0] raw);
      longint       x;
      longint       d1;
      longint       d2;
      logic [63:0]  cnt;
      logic [63:0]  mag1;
      logic [63:0]  mag2;
      logic [63:0]  quo;
      logic [63:0]  v;
      logic [127:0] total;
      logic         ovf;
      stats_t       e;
      x   = longint'($signed(raw));
      ovf = 1'b0;
      if (n_seen == CountMax) begin
        ovf = 1'b1;
      end else begin
        n_seen = n_seen + 1'b1;
        cnt    = 64'(n_seen);
        if (x > max_acc) max_acc = x;
        if (x < min_acc) min_acc = x;
        d1   = x - mean_acc;
        mag1 = (d1 < 0) ? -d1 : d1;
        quo  = mag1 / cnt;
        if (d1 < 0) begin
          mean_acc = mean_acc - longint'(quo);
        end else begin
          mean_acc = mean_acc + longint'(quo);
        end
        d2    = x - mean_acc;
        mag2  = (d2 < 0) ? -d2 : d2;
        total = {64'b0, mag1} * {64'b0, mag2} + {64'b0, sq_dev};
        if (total > {64'b0, {64{1'b1}}}) begin
          sq_dev = '1;
          ovf    = 1'b1;
        end else begin
          sq_dev = total[63:0];
        end
        if (cnt > 64'd1) begin
          v = sq_dev / (cnt - 64'd1);
          if (v > 64'(VarMax)) begin
            var_held = VarMax;
          end else begin
            var_held = v[VarW-1:0];
          end
        end
      end
      e.count    = n_seen;
      e.mean     = mean_acc[SampleW-1:0];
      e.low      = min_acc[SampleW-1:0];
      e.high     = max_acc[SampleW-1:0];
      e.variance = var_held;
      e.ovf      = ovf;
      expected_stats.push_back(e);
    endfunction

    task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
      errors++;
    endtask

    task check_stats(input stats_t got);
      stats_t e;
      if (expected_stats.size() == 0) begin
        report_mismatch("unexpected result count", 64'(got.count), 64'd0);
      end else begin
        e = expected_stats.pop_front();
        if (got.count !== e.count)
          report_mismatch("sample_count", 64'(got.count), 64'(e.count));
        if (got.mean !== e.mean)
          report_mismatch("running_mean", 64'(got.mean), 64'(e.mean));
        if (got.low !== e.low)
          report_mismatch("minimum", 64'(got.low), 64'(e.low));
        if (got.high !== e.high)
          report_mismatch("maximum", 64'(got.high), 64'(e.high));
        if (got.variance !== e.variance)
          report_mismatch("sample_variance", 64'(got.variance), 64'(e.variance));
        if (got.ovf !== e.ovf)
          report_mismatch("overflow", 64'(got.ovf), 64'(e.ovf));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic idling;
  int   stall_left;
  int   quiet_cycles;

  stats_tracker stats;

  rmv_in_if  sample_if ();
  rmv_out_if stats_if ();

  running_mean_variance_min_max i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (sample_if),
    .out_o  (stats_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic send_sample(input logic [SampleW-1:0] s);
    int gap;
    @(negedge clk_i);
    if (idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      sample_if.valid  = 1'b0;
      sample_if.sample = $urandom;
      repeat (gap) @(negedge clk_i);
    end
    sample_if.valid  = 1'b1;
    sample_if.sample = s;
    do @(posedge clk_i); while (!sample_if.ready);
    stats.record_sample(s);
  endtask

  function automatic logic [SampleW-1:0] pick_sample(input int centre,
                                                     input logic [SampleW-1:0] last);
    int unsigned amp;
    int          v;
    if ($urandom_range(0, 9) == 0) return last;
    amp = $urandom_range(0, 23);
    v   = int'($urandom & ((32'd1 << amp) - 1));
    if ($urandom_range(0, 1) == 1) v = -v;
    return centre + v;
  endfunction

  // Result side: random stall bursts, then the monitor at the rising edge.
  initial begin
    stats_if.ready = 1'b0;
    stall_left     = 0;
    forever begin
      @(negedge clk_i);
      if (idling && stall_left == 0 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12);
      end
      if (stall_left > 0) begin
        stats_if.ready = 1'b0;
        stall_left--;
      end else begin
        stats_if.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    stats_t got;
    if (rst_ni && stats_if.valid && stats_if.ready) begin
      got.count    = stats_if.sample_count;
      got.mean     = stats_if.running_mean;
      got.low      = stats_if.minimum;
      got.high     = stats_if.maximum;
      got.variance = stats_if.sample_variance;
      got.ovf      = stats_if.overflow;
      stats.check_stats(got);
    end
  end

  always @(posedge clk_i) begin
    if ((sample_if.valid && sample_if.ready) || (stats_if.valid && stats_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("[%0t] timeout: no request or result moved for %0d cycles",
               $realtime, QuietLimit);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [SampleW-1:0] directed_samples[$];
    logic [SampleW-1:0] last;
    int                 centre;
    stats            = new();
    quiet_cycles     = 0;
    idling           = 1'b1;
    rst_ni           = 1'b0;
    sample_if.valid  = 1'b0;
    sample_if.sample = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // The two extremes first: the widest delta, with m2 still below saturation.
    directed_samples = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000,
                         32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000,
                         32'h1234_5678, 32'hEDCB_A988, 32'h0000_0003, 32'hFFFF_FFFD,
                         32'h00AA_AAAA, 32'hFF55_5555, 32'h0000_8000, 32'hFFFF_8000};
    foreach (directed_samples[i]) send_sample(directed_samples[i]);

    last = '0;
    for (int chunk = 0; chunk < 11; chunk++) begin
      idling = ($urandom_range(0, 3) != 0);
      centre = int'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000;
      for (int k = 0; k < 98; k++) begin
        last = pick_sample(centre, last);
        send_sample(last);
      end
    end

    // Closing stretch without idling: drive m2 into saturation, then full-range noise.
    idling = 1'b0;
    for (int k = 0; k < 4; k++) begin
      send_sample(SampleMax);
      send_sample(SampleMin);
    end
    for (int k = 0; k < 40; k++) send_sample($urandom);

    @(negedge clk_i);
    sample_if.valid = 1'b0;
    while (stats.expected_stats.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (stats.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
